/* sv/multi_queue_linked_list_manager_assert.svh */
// Assertion macros used by the linked list manager.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_ASSERT_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define MQLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MQLL_ASSERT_NEXT(label, pre, post, msg) \
    `MQLL_ASSERT(label, (pre) |=> (post), msg)

`endif

/* sv/mqll_pkg.sv */
package mqll_pkg;

    localparam int ACT_W  = 2;
    localparam int ITEM_W = 10;
    localparam int LIST_W = 6;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

    // A link entry with its top bit set marks an item that is on no list.
    localparam logic [ITEM_W:0] LINK_OFF = {1'b1, {ITEM_W{1'b0}}};

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ITEM_W-1:0] item_id;
        logic [LIST_W-1:0] list_id;
    } mqll_in_t;

    typedef struct packed {
        logic [ITEM_W-1:0] popped_item;
        logic [STAT_W-1:0] status;
    } mqll_out_t;

    typedef struct packed {
        logic load;
        logic step1;
        logic fin_short;
        logic fin_long;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_second;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/mqll_dp.sv */
module mqll_dp
    import mqll_pkg::*;
#(
    parameter int NUM_ITEMS = 1023,
    parameter int NUM_LISTS = 63
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  mqll_in_t   s_data,
    output mqll_out_t  m_data,
    output logic       m_valid,
    input  logic       m_ready,
    input  ctrl_cmd_t  cmd,
    output dp_stat_t   stat
);

    localparam int ITEM_MAX   = (1 << ITEM_W) - 1;
    localparam int LIST_MAX   = (1 << LIST_W) - 1;
    localparam int LINK_DEPTH = ((NUM_ITEMS < ITEM_MAX) ? NUM_ITEMS : ITEM_MAX) + 1;
    localparam int LIST_DEPTH = ((NUM_LISTS < LIST_MAX) ? NUM_LISTS : LIST_MAX) + 1;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int LIST_AW    = $clog2(LIST_DEPTH);

    logic [ITEM_W:0]   link_mem [LINK_DEPTH];
    logic [ITEM_W-1:0] head_mem [LIST_DEPTH];
    logic [ITEM_W-1:0] tail_mem [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] head_vld_reg;

    mqll_in_t          req_reg;
    logic [ITEM_W-1:0] head_rd_reg;
    logic [ITEM_W-1:0] tail_rd_reg;
    logic              hv_rd_reg;
    logic [ITEM_W:0]   link_rd_reg;
    logic              m_valid_reg;
    mqll_out_t         m_data_reg;

    logic [ITEM_W-1:0]  head_cur;
    logic [LIST_AW-1:0] list_idx;
    logic [LIST_AW-1:0] s_list_idx;
    logic               list_ok;
    logic               item_ok;
    logic               tail_ok;
    logic               head_ok;
    logic               is_add;
    logic               add_ok;
    logic               need_pop;
    logic               link_we;
    logic [LINK_AW-1:0] link_wa;
    logic [ITEM_W:0]    link_wd;
    logic               head_we;
    logic [ITEM_W-1:0]  head_wd;
    logic               tail_we;
    logic [ITEM_W-1:0]  tail_wd;
    mqll_out_t          result;

    assign s_list_idx = s_data.list_id[LIST_AW-1:0];
    assign list_idx   = req_reg.list_id[LIST_AW-1:0];
    assign head_cur   = hv_rd_reg ? head_rd_reg : ITEM_W'(0);

    assign list_ok  = 32'(req_reg.list_id) <= 32'(NUM_LISTS);
    assign item_ok  = (req_reg.item_id != ITEM_W'(0))
                      && (32'(req_reg.item_id) <= 32'(NUM_ITEMS));
    assign tail_ok  = 32'(tail_rd_reg) <= 32'(NUM_ITEMS);
    assign head_ok  = (head_cur != ITEM_W'(0)) && (32'(head_cur) <= 32'(NUM_ITEMS));
    assign is_add   = (req_reg.action == ACT_APPEND) || (req_reg.action == ACT_PUSH);
    assign add_ok   = is_add && item_ok && list_ok;
    assign need_pop = (req_reg.action == ACT_POP) && list_ok && head_ok;

    assign stat.need_second = need_pop
        || (add_ok && (req_reg.action == ACT_APPEND) && (head_cur != ITEM_W'(0)));
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        result.popped_item = need_pop ? head_cur : ITEM_W'(0);
        result.status      = ST_DONE;
        if (is_add && !add_ok) begin
            result.status = ST_IGNORED;
        end else if ((req_reg.action == ACT_POP) && !need_pop) begin
            result.status = ST_EMPTY;
        end
    end

    always_comb begin
        link_we = 1'b0;
        link_wa = req_reg.item_id[LINK_AW-1:0];
        link_wd = '0;
        head_we = 1'b0;
        head_wd = req_reg.item_id;
        tail_we = 1'b0;
        tail_wd = req_reg.item_id;
        if (cmd.step1 && !need_pop && tail_ok) begin
            link_we = 1'b1;
            link_wa = tail_rd_reg[LINK_AW-1:0];
            link_wd = {1'b0, req_reg.item_id};
        end
        if (cmd.fin_short && add_ok) begin
            link_we = 1'b1;
            head_we = 1'b1;
            if (req_reg.action == ACT_APPEND) begin
                tail_we = 1'b1;
            end else begin
                tail_we = (head_cur == ITEM_W'(0));
                link_wd = {1'b0, head_cur};
            end
        end
        if (cmd.fin_long) begin
            if (need_pop) begin
                head_we = 1'b1;
                head_wd = link_rd_reg[ITEM_W] ? ITEM_W'(0) : link_rd_reg[ITEM_W-1:0];
                link_we = 1'b1;
                link_wa = head_cur[LINK_AW-1:0];
                link_wd = LINK_OFF;
            end else begin
                link_we = 1'b1;
                tail_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_data;
            head_rd_reg <= head_mem[s_list_idx];
            tail_rd_reg <= tail_mem[s_list_idx];
            hv_rd_reg   <= head_vld_reg[s_list_idx];
        end
        link_rd_reg <= link_mem[head_cur[LINK_AW-1:0]];
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (head_we) begin
            head_mem[list_idx] <= head_wd;
        end
        if (tail_we) begin
            tail_mem[list_idx] <= tail_wd;
        end
        if (cmd.fin_short || cmd.fin_long) begin
            m_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (head_we) begin
                head_vld_reg[list_idx] <= 1'b1;
            end
            if (cmd.fin_short || cmd.fin_long) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/mqll_ctrl.sv */
module mqll_ctrl
    import mqll_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LINK
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (stat.need_second) begin
                        state_reg <= S_LINK;
                    end else if (stat.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LINK: begin
                    if (stat.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        cmd.load      = s_valid && (state_reg == S_IDLE);
        cmd.step1     = (state_reg == S_LOOK) && stat.need_second;
        cmd.fin_short = (state_reg == S_LOOK) && !stat.need_second && stat.out_free;
        cmd.fin_long  = (state_reg == S_LINK) && stat.out_free;
    end

endmodule

/* sv/multi_queue_linked_list_manager.sv */
// Linked list manager for a pool of items shared by a set of singly linked lists.
// An input transaction on the s_ channel carries an action (append at tail,
// push at head or pop from head), an item number and a list number. Each
// input transaction yields exactly one result transaction on the m_ channel
// with the popped item and a status code (done, add ignored, pop on empty).
// Items are taken one at a time. A push, an append to an empty list, an
// ignored add, a pop of an empty list and an unused action code present
// their result from the S_LOOK state once the output register is free. An
// append to a non-empty list and a pop that removes an item also pass
// through S_LINK before their result, because the single port of the link memory
// is used twice in a row (link read then write for a pop, two link writes for
// an append). s_ready is high again in the cycle in which the result appears.
// Results wait in an output register; while the receiver holds m_ready low,
// the finished transaction stays there and the next one, once accepted,
// waits in its last step without changing any table.
// Reset clears the head valid bits, so every list is empty at once, and
// empties the output register; no clearing pass is needed.
`include "multi_queue_linked_list_manager_assert.svh"

module multi_queue_linked_list_manager
    import mqll_pkg::*;
#(
    parameter int NUM_ITEMS = 1023,
    parameter int NUM_LISTS = 63
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mqll_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mqll_out_t m_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mqll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mqll_dp #(
        .NUM_ITEMS (NUM_ITEMS),
        .NUM_LISTS (NUM_LISTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    `MQLL_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second transaction accepted while busy")
    `MQLL_ASSERT(a_result_frees_input, $rose(m_valid) |-> s_ready, "result shown without input freed")
    `MQLL_ASSERT(a_fail_pops_nothing, (m_valid && (m_data.status != ST_DONE)) |-> (m_data.popped_item == '0), "failed transaction returns an item")
    `MQLL_ASSERT(a_one_command, $onehot0({cmd.load, cmd.step1, cmd.fin_short, cmd.fin_long}), "controller issued two commands at once")

endmodule

/* tb/tb_top.sv */
module tb_top;
    import mqll_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;

    // The package names no code for the fourth action value.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mqll_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mqll_out_t m_data;

    multi_queue_linked_list_manager u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the link store and the head and tail tables.
    logic [ITEM_W:0]   link_tab [0:(1<<ITEM_W)-1];
    logic [ITEM_W-1:0] head_tab [0:(1<<LIST_W)-1];
    logic [ITEM_W-1:0] tail_tab [0:(1<<LIST_W)-1];

    mqll_out_t pending_results[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  items_popped = 0;
    int  empty_pops = 0;
    int  ignored_adds = 0;
    int  hold_len = 0;
    bit  quiet = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic void clear_lists();
        for (int k = 0; k < (1 << ITEM_W); k++) begin
            link_tab[k] = LINK_OFF;
        end
        for (int k = 0; k < (1 << LIST_W); k++) begin
            head_tab[k] = '0;
            tail_tab[k] = '0;
        end
    endfunction

    // Applies one action to the shadow lists and returns the result it yields.
    function automatic mqll_out_t run_list_op(mqll_in_t op);
        mqll_out_t         res;
        logic [ITEM_W-1:0] hd;
        logic [ITEM_W:0]   nx;
        res = '0;
        hd  = head_tab[op.list_id];
        case (op.action)
            ACT_APPEND, ACT_PUSH: begin
                if (op.item_id == '0) begin
                    res.status = ST_IGNORED;
                end else if (op.action == ACT_APPEND) begin
                    if (hd == '0) begin
                        head_tab[op.list_id] = op.item_id;
                    end else begin
                        link_tab[tail_tab[op.list_id]] = {1'b0, op.item_id};
                    end
                    tail_tab[op.list_id] = op.item_id;
                    link_tab[op.item_id] = '0;
                end else begin
                    if (hd == '0) begin
                        tail_tab[op.list_id] = op.item_id;
                    end
                    link_tab[op.item_id] = {1'b0, hd};
                    head_tab[op.list_id] = op.item_id;
                end
            end
            ACT_POP: begin
                if (hd == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    nx = link_tab[hd];
                    head_tab[op.list_id] = nx[ITEM_W] ? '0 : nx[ITEM_W-1:0];
                    link_tab[hd] = LINK_OFF;
                    res.popped_item = hd;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Prefers an item that is on no list, but now and then reuses one.
    function automatic logic [ITEM_W-1:0] pick_item();
        logic [ITEM_W-1:0] it;
        it = ITEM_W'($urandom_range(1, (1 << ITEM_W) - 1));
        if ($urandom_range(0, 99) < 5) begin
            return it;
        end
        for (int k = 0; k < 8 && !link_tab[it][ITEM_W]; k++) begin
            it = ITEM_W'($urandom_range(1, (1 << ITEM_W) - 1));
        end
        return it;
    endfunction

    function automatic mqll_in_t random_op();
        mqll_in_t op;
        int       roll;
        roll = $urandom_range(0, 99);
        op.list_id = ($urandom_range(0, 99) < 80) ? LIST_W'($urandom_range(0, 7))
                                                  : LIST_W'($urandom_range(0, 63));
        op.item_id = ITEM_W'($urandom);
        if (roll < 4) begin
            op.action = ACT_UNUSED;
        end else if (roll < 8) begin
            op.action  = ($urandom_range(0, 1) == 0) ? ACT_APPEND : ACT_PUSH;
            op.item_id = '0;
        end else if (roll < 45) begin
            op.action  = ACT_APPEND;
            op.item_id = pick_item();
        end else if (roll < 65) begin
            op.action  = ACT_PUSH;
            op.item_id = pick_item();
        end else begin
            op.action = ACT_POP;
        end
        return op;
    endfunction

    // Offers one transaction after a random gap and records its expected result.
    task automatic send_op(input mqll_in_t op);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(run_list_op(op));
        items_sent++;
    endtask

    task automatic send_fields(input logic [ACT_W-1:0] act, input int item, input int lst);
        mqll_in_t op;
        op.action  = act;
        op.item_id = ITEM_W'(item);
        op.list_id = LIST_W'(lst);
        send_op(op);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stalls per transaction, with an occasional long hold-off.
    initial begin
        int        stall;
        mqll_out_t exp_res;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (m_data.status == ST_EMPTY) empty_pops++;
            if (m_data.status == ST_IGNORED) ignored_adds++;
            if (m_data.popped_item != '0) items_popped++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected result transaction: item %0d status %0d",
                             m_data.popped_item, m_data.status);
                end
            end else begin
                exp_res = pending_results.pop_front();
                if (m_data.popped_item !== exp_res.popped_item
                    || m_data.status !== exp_res.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch: expected item %0d status %0d, got item %0d status %0d",
                                 exp_res.popped_item, exp_res.status,
                                 m_data.popped_item, m_data.status);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_fields(ACT_POP, 0, 0);
        send_fields(ACT_APPEND, 0, 5);
        send_fields(ACT_PUSH, 0, 63);
        send_fields(ACT_UNUSED, 1023, 63);
        send_fields(ACT_APPEND, 1023, 0);
        send_fields(ACT_APPEND, 1, 63);
        send_fields(ACT_PUSH, 512, 63);
        send_fields(ACT_POP, 1023, 63);
        send_fields(ACT_POP, 0, 63);
        send_fields(ACT_POP, 0, 63);
        send_fields(ACT_APPEND, 341, 42);
        send_fields(ACT_PUSH, 682, 42);
        send_fields(ACT_POP, 0, 42);
        send_fields(ACT_POP, 0, 42);
        send_fields(ACT_POP, 0, 42);
        // The same item added to two lists, then popped from both.
        send_fields(ACT_APPEND, 7, 1);
        send_fields(ACT_APPEND, 7, 2);
        send_fields(ACT_POP, 0, 2);
        send_fields(ACT_POP, 0, 1);
        send_fields(ACT_POP, 0, 1);
        send_fields(ACT_POP, 0, 0);
        send_fields(ACT_PUSH, 21, 21);
        send_fields(ACT_APPEND, 21, 21);
        send_fields(ACT_POP, 0, 21);
        wait_drained();
    endtask

    task automatic test_backpressure();
        mqll_in_t op;
        quiet    = 1;
        hold_len = LONG_HOLD;
        for (int n = 0; n < 40; n++) begin
            op = random_op();
            send_op(op);
        end
        quiet = 0;
        wait_drained();
    endtask

    task automatic test_random_mix(input int count);
        mqll_in_t op;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                quiet = ($urandom_range(0, 99) < 30);
            end
            if (n % 200 == 199) begin
                wait_drained();
            end
            op = random_op();
            send_op(op);
        end
        quiet = 0;
        wait_drained();
    endtask

    initial begin
        clear_lists();
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random_mix(840);
        $display("Sent %0d transactions: %0d items popped, %0d empty pops, %0d adds ignored.",
                 items_sent, items_popped, empty_pops, ignored_adds);
        $display("Covered shared items, unused actions, list zero and a long output stall.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding.",
                     mismatches, pending_results.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mqll_pkg.sv
sv/mqll_dp.sv
sv/mqll_ctrl.sv
sv/multi_queue_linked_list_manager.sv
tb/tb_top.sv
